// ===== rtl/core/hsv2rgb_pkg.sv =====
// Shared types, sector codes and the channel scaling function for the
// HSV to RGB converter pipeline. No dependencies.
`timescale 1ns / 1ps

package hsv2rgb_pkg;

	// Hue sectors, each one sixth of a turn.
	localparam logic [2:0] SECTOR_RED_YELLOW    = 3'd0;
	localparam logic [2:0] SECTOR_YELLOW_GREEN  = 3'd1;
	localparam logic [2:0] SECTOR_GREEN_CYAN    = 3'd2;
	localparam logic [2:0] SECTOR_CYAN_BLUE     = 3'd3;
	localparam logic [2:0] SECTOR_BLUE_MAGENTA  = 3'd4;
	localparam logic [2:0] SECTOR_MAGENTA_RED   = 3'd5;

	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// Fractions are held as unsigned integers over 2^24.
	localparam int unsigned FRAC_BITS = 24;

	// Stage 1 result: saturation products and the value carried along.
	typedef struct packed {
		logic [7:0]  value;
		logic [2:0]  sector;
		logic [8:0]  one_minus_s;
		logic [15:0] s_times_f;
		logic [15:0] s_times_nf;
	} s1_data_t;

	// Stage 2 result: the p, q and t fractions, v kept as its code.
	typedef struct packed {
		logic [7:0]           value;
		logic [2:0]           sector;
		logic [FRAC_BITS-1:0] frac_p;
		logic [FRAC_BITS-1:0] frac_q;
		logic [FRAC_BITS-1:0] frac_t;
	} s2_data_t;

	// Stage 3 result: the finished pixel.
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	// floor(255 * n / 2^24), with 255 * n formed as (n << 8) - n.
	function automatic logic [7:0] channel_code(input logic [FRAC_BITS-1:0] n);
		logic [FRAC_BITS+7:0] scaled;
		scaled = {n, 8'h00} - {8'h00, n};
		return scaled[FRAC_BITS+7:FRAC_BITS];
	endfunction

endpackage

// ===== rtl/core/hsv2rgb_front.sv =====
// First pipeline stage: splits the hue into sector and fraction and forms
// the saturation products. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  logic [7:0]             hue,
	input  logic [7:0]             saturation,
	input  logic [7:0]             brightness,
	output logic                   valid_s1,
	output hsv2rgb_pkg::s1_data_t  data_s1
);

	logic [10:0] hue6;
	logic [7:0]  frac;
	logic [8:0]  not_frac;
	logic [15:0] s_nf_wide;
	hsv2rgb_pkg::s1_data_t next;

	always_comb begin
		hue6      = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
		frac      = hue6[7:0];
		not_frac  = 9'd256 - {1'b0, frac};
		// At most 255 * 256, so sixteen bits hold it.
		s_nf_wide = {8'h00, saturation} * {7'h00, not_frac};

		next.value       = brightness;
		next.sector      = hue6[10:8];
		next.one_minus_s = 9'd256 - {1'b0, saturation};
		next.s_times_f   = {8'h00, saturation} * {8'h00, frac};
		next.s_times_nf  = s_nf_wide;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s1 <= next;
		end
	end

endmodule

// ===== rtl/core/hsv2rgb_scale.sv =====
// Second pipeline stage: multiplies the value by the saturation terms to
// get the p, q and t fractions. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_scale (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  hsv2rgb_pkg::s1_data_t  data_in,
	output logic                   valid_s2,
	output hsv2rgb_pkg::s2_data_t  data_s2
);

	logic [15:0] vp_prod;
	logic [23:0] vq_prod;
	logic [23:0] vt_prod;
	hsv2rgb_pkg::s2_data_t next;

	always_comb begin
		// v * (256 - s) stays below 2^16; the other two stay below 2^24.
		vp_prod = {8'h00, data_in.value} * {7'h00, data_in.one_minus_s};
		vq_prod = {16'h0000, data_in.value} *
			(24'h010000 - {8'h00, data_in.s_times_f});
		vt_prod = {16'h0000, data_in.value} *
			(24'h010000 - {8'h00, data_in.s_times_nf});

		next.value  = data_in.value;
		next.sector = data_in.sector;
		// Shifting v * (256 - s) by 8 lands it over 2^24.
		next.frac_p = {vp_prod, 8'h00};
		next.frac_q = vq_prod;
		next.frac_t = vt_prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			data_s2 <= next;
		end
	end

endmodule

// ===== rtl/core/hsv2rgb_mix.sv =====
// Third pipeline stage: permutes v, p, q and t by sector and scales each
// channel to an 8-bit code. Depends on hsv2rgb_pkg.
`timescale 1ns / 1ps

module hsv2rgb_mix (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  hsv2rgb_pkg::s2_data_t  data_in,
	output logic                   valid_s3,
	output hsv2rgb_pkg::pixel_t    pixel_s3
);

	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac_v;
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac_r;
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac_g;
	logic [hsv2rgb_pkg::FRAC_BITS-1:0] frac_b;
	hsv2rgb_pkg::pixel_t next;

	always_comb begin
		frac_v = {data_in.value, 16'h0000};
		case (data_in.sector)
			hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
				frac_r = frac_v;          frac_g = data_in.frac_t; frac_b = data_in.frac_p;
			end
			hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
				frac_r = data_in.frac_q;  frac_g = frac_v;         frac_b = data_in.frac_p;
			end
			hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
				frac_r = data_in.frac_p;  frac_g = frac_v;         frac_b = data_in.frac_t;
			end
			hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
				frac_r = data_in.frac_p;  frac_g = data_in.frac_q; frac_b = frac_v;
			end
			hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
				frac_r = data_in.frac_t;  frac_g = data_in.frac_p; frac_b = frac_v;
			end
			default: begin
				frac_r = frac_v;          frac_g = data_in.frac_p; frac_b = data_in.frac_q;
			end
		endcase
		next.red   = hsv2rgb_pkg::channel_code(frac_r);
		next.green = hsv2rgb_pkg::channel_code(frac_g);
		next.blue  = hsv2rgb_pkg::channel_code(frac_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && valid_in) begin
			pixel_s3 <= next;
		end
	end

endmodule

// ===== rtl/core/hsv_to_rgb_pixel_converter_core.sv =====
// Top level of the HSV to RGB pixel converter: three pipeline stages and
// the handshake control. Depends on hsv2rgb_pkg and the three stage modules.
`timescale 1ns / 1ps

// This block converts one 8-bit HSV pixel per clock into 8-bit red, green
// and blue plus a packed ARGB word with alpha fixed at 255. Each input
// code n is read as n/256; hue times six selects one of six sectors and a
// fraction, and the channels come out as floor(255 * fraction) with exact
// integer arithmetic, so a zero saturation always gives a grey pixel. A
// request passes three register stages: saturation products, value
// multiplies, then the sector permutation with channel scaling. The first
// stage loads at the accepting edge, and the result then passes the second
// and third stage registers before it is on the output. The pipeline
// accepts a new request every cycle while results are taken. A stall on
// the output holds the finished result in the last stage, and earlier
// stages keep filling any empty slots, so the input is stalled only once
// all three stages hold a request. There is no configuration and no
// state beyond the pipeline itself.
module hsv_to_rgb_pixel_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        hsv_valid,
	output logic        hsv_stall,
	input  logic [7:0]  hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        rgb_valid,
	input  logic        rgb_stall,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [31:0] argb_word
);

	logic                  valid_s1;
	logic                  valid_s2;
	logic                  valid_s3;
	logic                  en_s1;
	logic                  en_s2;
	logic                  en_s3;
	hsv2rgb_pkg::s1_data_t data_s1;
	hsv2rgb_pkg::s2_data_t data_s2;
	hsv2rgb_pkg::pixel_t   pixel_s3;

	// A stage may load when it is empty or its content moves on this cycle.
	assign en_s3 = !valid_s3 || !rgb_stall;
	assign en_s2 = !valid_s2 || en_s3;
	assign en_s1 = !valid_s1 || en_s2;

	assign hsv_stall = !en_s1;

	hsv2rgb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en_s1),
		.valid_in   (hsv_valid),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.valid_s1   (valid_s1),
		.data_s1    (data_s1)
	);

	hsv2rgb_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s2),
		.valid_in (valid_s1),
		.data_in  (data_s1),
		.valid_s2 (valid_s2),
		.data_s2  (data_s2)
	);

	hsv2rgb_mix u_mix (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en_s3),
		.valid_in (valid_s2),
		.data_in  (data_s2),
		.valid_s3 (valid_s3),
		.pixel_s3 (pixel_s3)
	);

	assign rgb_valid = valid_s3;
	assign red       = pixel_s3.red;
	assign green     = pixel_s3.green;
	assign blue      = pixel_s3.blue;
	assign argb_word = {hsv2rgb_pkg::ALPHA_OPAQUE, pixel_s3.red, pixel_s3.green, pixel_s3.blue};

	// The input is held off only when every stage is full and the output stalls.
	assert property (@(posedge clk) disable iff (!arst_n)
		hsv_stall |-> (valid_s1 && valid_s2 && valid_s3 && rgb_stall))
		else $error("input stalled while the pipeline has room");

	// A request in stage one that is allowed to move reaches stage two.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && en_s2) |=> valid_s2)
		else $error("request lost between stage one and stage two");

	// A taken result with nothing behind it leaves the output empty.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rgb_valid && !rgb_stall && !valid_s2) |=> !rgb_valid)
		else $error("result repeated on the output");

	// A request accepted into an empty pipeline passes stage one and then sits in stage two.
	assert property (@(posedge clk) disable iff (!arst_n)
		(hsv_valid && !hsv_stall && !valid_s1 && !valid_s2 && !valid_s3) |=> ##1 valid_s2)
		else $error("request did not advance through an empty pipeline");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the HSV to RGB pixel converter core.
// Depends on hsv2rgb_pkg and hsv_to_rgb_pixel_converter_core.
`timescale 1ns / 1ps

module tb;

	localparam int N_DIRECTED  = 17;
	localparam int N_RANDOM    = 940;
	localparam int N_TOTAL     = N_DIRECTED + N_RANDOM;
	// No idling on either side once this many requests or results are through.
	localparam int CALM_TAIL   = N_TOTAL - 150;
	// Limit on the length of the whole run, with a wide margin.
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_WAIT  = 12;

	// One row of stimulus. When has_known is set, known_px is the expected
	// pixel written out by hand; otherwise the color model supplies it.
	typedef struct packed {
		logic [7:0]          hue;
		logic [7:0]          sat;
		logic [7:0]          val;
		logic                has_known;
		hsv2rgb_pkg::pixel_t known_px;
	} pixel_req_t;

	// Directed rows: grey and black pixels with their obvious results, then
	// one fully saturated pixel per sector, the hue extremes, sector edges
	// and the smallest nonzero codes.
	localparam pixel_req_t DIRECTED_ROWS [N_DIRECTED] = '{
		'{8'd0,   8'd0,   8'd0,   1'b1, 24'h000000},
		'{8'd255, 8'd0,   8'd255, 1'b1, 24'hFEFEFE},
		'{8'd128, 8'd0,   8'd128, 1'b1, 24'h7F7F7F},
		'{8'd255, 8'd255, 8'd0,   1'b1, 24'h000000},
		'{8'd0,   8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd43,  8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd86,  8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd128, 8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd171, 8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd214, 8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd255, 8'd255, 8'd255, 1'b0, 24'h000000},
		'{8'd42,  8'd200, 8'd200, 1'b0, 24'h000000},
		'{8'd85,  8'd128, 8'd255, 1'b0, 24'h000000},
		'{8'd170, 8'd1,   8'd255, 1'b0, 24'h000000},
		'{8'd213, 8'd254, 8'd1,   1'b0, 24'h000000},
		'{8'd127, 8'd255, 8'd128, 1'b0, 24'h000000},
		'{8'd1,   8'd1,   8'd1,   1'b0, 24'h000000}
	};

	// Hues on both sides of every sector boundary, plus the ends of the range.
	localparam logic [7:0] EDGE_HUES [13] = '{
		8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127, 8'd128,
		8'd170, 8'd171, 8'd212, 8'd213, 8'd214, 8'd255
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        hsv_valid = 1'b0;
	logic        hsv_stall;
	logic [7:0]  hue = 8'd0;
	logic [7:0]  saturation = 8'd0;
	logic [7:0]  brightness = 8'd0;
	logic        rgb_valid;
	logic        rgb_stall = 1'b0;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [31:0] argb_word;

	pixel_req_t          pending_reqs[$];
	pixel_req_t          req_on_bus;
	hsv2rgb_pkg::pixel_t expected_pixels[$];

	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned reqs_accepted = 0;
	int unsigned pixels_checked = 0;
	int unsigned grey_pixels = 0;
	int unsigned error_count = 0;
	int unsigned cycle_count = 0;

	hsv_to_rgb_pixel_converter_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.hsv_valid  (hsv_valid),
		.hsv_stall  (hsv_stall),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.rgb_valid  (rgb_valid),
		.rgb_stall  (rgb_stall),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.argb_word  (argb_word)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// A channel fraction n over 2^24 becomes floor(255 * n / 2^24).
	function automatic logic [7:0] frac_to_code(input longint unsigned n);
		longint unsigned scaled;
		scaled = (n * 64'd255) >> 24;
		return scaled[7:0];
	endfunction

	// Color model: splits hue into sector and fraction, forms the v, p, q
	// and t fractions exactly over 2^24, and routes them by sector.
	function automatic hsv2rgb_pkg::pixel_t hsv_to_rgb_pixel(input logic [7:0] h,
			input logic [7:0] s, input logic [7:0] v);
		longint unsigned h6, f, lv, ls;
		longint unsigned fr_v, fr_p, fr_q, fr_t;
		longint unsigned fr_r, fr_g, fr_b;
		logic [2:0] sector;
		hsv2rgb_pkg::pixel_t px;
		lv = v;
		ls = s;
		h6 = longint'(h) * 6;
		sector = h6[10:8];
		f = h6 & 64'hFF;
		fr_v = lv << 16;
		fr_p = (lv * (256 - ls)) << 8;
		fr_q = lv * (65536 - ls * f);
		fr_t = lv * (65536 - ls * (256 - f));
		case (sector)
			hsv2rgb_pkg::SECTOR_RED_YELLOW: begin
				fr_r = fr_v; fr_g = fr_t; fr_b = fr_p;
			end
			hsv2rgb_pkg::SECTOR_YELLOW_GREEN: begin
				fr_r = fr_q; fr_g = fr_v; fr_b = fr_p;
			end
			hsv2rgb_pkg::SECTOR_GREEN_CYAN: begin
				fr_r = fr_p; fr_g = fr_v; fr_b = fr_t;
			end
			hsv2rgb_pkg::SECTOR_CYAN_BLUE: begin
				fr_r = fr_p; fr_g = fr_q; fr_b = fr_v;
			end
			hsv2rgb_pkg::SECTOR_BLUE_MAGENTA: begin
				fr_r = fr_t; fr_g = fr_p; fr_b = fr_v;
			end
			default: begin
				fr_r = fr_v; fr_g = fr_p; fr_b = fr_q;
			end
		endcase
		px.red = frac_to_code(fr_r);
		px.green = frac_to_code(fr_g);
		px.blue = frac_to_code(fr_b);
		return px;
	endfunction

	task automatic check_field(input string field, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			error_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	// Request side. Valid drops only after a request has been taken, so it
	// never reacts to the stall of the current cycle.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hsv_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (hsv_valid && !hsv_stall) begin
				if (req_on_bus.has_known)
					expected_pixels.push_back(req_on_bus.known_px);
				else
					expected_pixels.push_back(hsv_to_rgb_pixel(req_on_bus.hue,
						req_on_bus.sat, req_on_bus.val));
				reqs_accepted++;
			end
			if (!hsv_valid || !hsv_stall) begin
				if (gap_left > 0) begin
					hsv_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pending_reqs.size() == 0) begin
					hsv_valid <= 1'b0;
				end else if (reqs_accepted < CALM_TAIL && ((reqs_accepted >> 7) % 3) != 2
						&& $urandom_range(0, 5) == 0) begin
					// Idle burst, this one included; gap_left counts the idle cycles still to come.
					hsv_valid <= 1'b0;
					gap_left <= $urandom_range(0, 9);
				end else begin
					req_on_bus = pending_reqs.pop_front();
					hue <= req_on_bus.hue;
					saturation <= req_on_bus.sat;
					brightness <= req_on_bus.val;
					hsv_valid <= 1'b1;
				end
			end
		end
	end

	// Result side: random stall bursts, with quiet stretches and a quiet tail.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left > 0) begin
			rgb_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (pixels_checked < CALM_TAIL && ((pixels_checked >> 7) % 3) != 1
				&& $urandom_range(0, 4) == 0) begin
			rgb_stall <= 1'b1;
			stall_left <= $urandom_range(0, 9);
		end else begin
			rgb_stall <= 1'b0;
		end
	end

	// Every taken result is matched against the oldest expected pixel.
	always @(posedge clk) begin
		hsv2rgb_pkg::pixel_t want;
		if (arst_n && rgb_valid && !rgb_stall) begin
			if (expected_pixels.size() == 0) begin
				error_count++;
				$display("%0t: result with no request outstanding, actual %h", $time,
					argb_word);
			end else begin
				want = expected_pixels.pop_front();
				check_field("red", 32'(want.red), 32'(red));
				check_field("green", 32'(want.green), 32'(green));
				check_field("blue", 32'(want.blue), 32'(blue));
				check_field("argb_word",
					{hsv2rgb_pkg::ALPHA_OPAQUE, want.red, want.green, want.blue},
					argb_word);
				if (want.red == want.green && want.green == want.blue)
					grey_pixels++;
				pixels_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still outstanding", cycle_count,
				expected_pixels.size());
			$display("hsv_to_rgb_pixel_converter_core test failed");
			$finish;
		end
	end

	initial begin
		pixel_req_t rq;
		int kind;
		for (int i = 0; i < N_DIRECTED; i++)
			pending_reqs.push_back(DIRECTED_ROWS[i]);
		// Random requests, biased toward grey, full saturation, full value
		// and hues next to a sector boundary.
		for (int i = 0; i < N_RANDOM; i++) begin
			rq.hue = $urandom_range(0, 255);
			rq.sat = $urandom_range(0, 255);
			rq.val = $urandom_range(0, 255);
			rq.has_known = 1'b0;
			rq.known_px = '0;
			kind = $urandom_range(0, 9);
			case (kind)
				0: rq.sat = 8'd0;
				1: rq.sat = 8'd255;
				2: rq.val = 8'd255;
				3: rq.hue = EDGE_HUES[$urandom_range(0, 12)];
				default: ;
			endcase
			pending_reqs.push_back(rq);
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait until every request has been taken, then until every result is back.
		while (reqs_accepted < N_TOTAL)
			@(posedge clk);
		while (expected_pixels.size() != 0)
			@(posedge clk);
		// Give a stray extra result time to show up.
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d requests sent (%0d directed), %0d pixels checked, %0d of them grey",
			reqs_accepted, N_DIRECTED, pixels_checked, grey_pixels);
		$display("idle and stall bursts on both sides, quiet stretches and a quiet tail");
		if (error_count == 0)
			$display("hsv_to_rgb_pixel_converter_core test passed");
		else
			$display("hsv_to_rgb_pixel_converter_core test failed");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/hsv2rgb_pkg.sv
rtl/core/hsv2rgb_front.sv
rtl/core/hsv2rgb_scale.sv
rtl/core/hsv2rgb_mix.sv
rtl/core/hsv_to_rgb_pixel_converter_core.sv
verif/tb.sv
